/* rtl/assert_macros.svh */
// Assertion macros shared by the operand address unit RTL.
// Each macro expands to a concurrent assertion in simulation and to nothing
// when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define OAU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("operand address unit: same-cycle check failed");

`define OAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("operand address unit: next-cycle check failed");

`else

`define OAU_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define OAU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/oau_pkg.sv */
// Shared types and constants for the 6502 operand address unit.
// Used by the byte store and the top level; depends on nothing else.
package oau_pkg;

	localparam int STORE_DEPTH_DEF = 65536;
	localparam int ADDR_W          = 16;
	localparam int DATA_W          = 8;

	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_RESOLVE = 1'b1;

	typedef enum logic [3:0] {
		MODE_IMM     = 4'd0,
		MODE_ZP      = 4'd1,
		MODE_ZPX     = 4'd2,
		MODE_ZPY     = 4'd3,
		MODE_ABS     = 4'd4,
		MODE_ABSX    = 4'd5,
		MODE_ABSY    = 4'd6,
		MODE_INDX    = 4'd7,
		MODE_INDY    = 4'd8,
		MODE_IND     = 4'd9,
		MODE_REL     = 4'd10,
		MODE_ACC     = 4'd11,
		MODE_IMPLIED = 4'd12
	} mode_t;

	// Input transaction payload, last field in the lowest bits.
	typedef struct packed {
		logic [3:0]        pad;
		logic [DATA_W-1:0] store_data;
		logic [ADDR_W-1:0] store_address;
		logic [7:0]        index_y;
		logic [7:0]        index_x;
		logic [7:0]        operand_high;
		logic [7:0]        operand_low;
		logic [ADDR_W-1:0] pc;
		logic [3:0]        mode;
	} in_item_t;

	// One access of the single-port byte store.
	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wdata;
	} store_req_t;

endpackage

/* rtl/cpu6502_operand_address_unit.sv */
// Top level of the 6502 operand effective-address unit.
// Depends on oau_pkg, oau_store and assert_macros.svh.
`include "assert_macros.svh"

// A load transaction (tuser action bit low) writes one byte into the byte
// store and answers with an all-zero result. A resolve transaction (action
// bit high) turns an addressing mode, the opcode address, the two operand
// bytes and X and Y into an effective address, a page-cross flag and an
// accumulator flag. Loads and the direct modes register their result at the
// accept edge. The three indirect modes (indexed indirect X, indirect indexed
// Y and JMP indirect) pass through S_RD_HI and S_DONE, because both pointer
// bytes come through the single port of the store, whose read data arrives
// in the cycle after the address: the low byte is read in the accept cycle,
// the high byte in S_RD_HI; the result is formed in S_DONE. Input is taken
// only when the FSM is idle and the output register is empty or being
// drained, so a result waiting downstream holds off the next transaction.
// The byte store has no reset; a pointer byte that was never loaded reads
// as an arbitrary value. STORE_DEPTH must be a power of two between 256 and
// 65536; store addresses wrap modulo the depth on writes and reads alike.
module cpu6502_operand_address_unit #(
	parameter int STORE_DEPTH = oau_pkg::STORE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input transactions.
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata from bit 0 up: mode[3:0], pc[15:0], operand_low[7:0],
	// operand_high[7:0], index_x[7:0], index_y[7:0], store_address[15:0],
	// store_data[7:0], four zero bits.
	input  logic [79:0] s_tdata,
	// tuser: action (0 load, 1 resolve).
	input  logic [0:0]  s_tuser,
	// Result transactions.
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata from bit 0 up: effective_address[15:0], extra_cycle, seven zero bits.
	output logic [23:0] m_tdata,
	// tuser: selects_accumulator.
	output logic [0:0]  m_tuser
);
	import oau_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD_HI,
		S_DONE
	} state_t;

	state_t            state_q;
	in_item_t          item;
	logic              accept;
	logic              is_resolve;
	logic              is_indirect;
	logic              out_load;

	// Registered output and the context of an indirect transaction in flight.
	logic              m_tvalid_q;
	logic [15:0]       ea_q;
	logic              extra_q;
	logic              acc_q;
	logic [3:0]        mode_q;
	logic [7:0]        y_q;
	logic [15:0]       ptr_hi_addr_q;
	logic [7:0]        ptr_lo_q;

	// Direct-mode result, ready in the accept cycle.
	logic [15:0]       dir_ea;
	logic              dir_extra;
	logic              dir_acc;
	logic [15:0]       abs_base;
	logic [15:0]       abs_sum;
	logic [7:0]        zp_x;
	logic [15:0]       ptr_lo_addr;
	logic [15:0]       ptr_hi_addr;

	// Indirect result, ready in state S_DONE.
	logic [15:0]       ptr;
	logic [15:0]       ind_sum;
	logic [15:0]       ind_ea;
	logic              ind_extra;

	store_req_t        sreq;
	logic [DATA_W-1:0] srdata;

	assign item        = in_item_t'(s_tdata);
	assign is_resolve  = (s_tuser[0] == ACT_RESOLVE);
	assign is_indirect = is_resolve && (item.mode inside {MODE_INDX, MODE_INDY, MODE_IND});
	assign s_tready    = (state_q == S_IDLE) && (!m_tvalid_q || m_tready);
	assign accept      = s_tvalid && s_tready;
	// The output register takes a new result from a direct transaction at its
	// accept edge, or from an indirect one at the end of its result cycle.
	assign out_load    = (state_q == S_DONE) || (accept && !is_indirect);

	assign abs_base = {item.operand_high, item.operand_low};
	assign zp_x     = item.operand_low + item.index_x;

	always_comb begin
		abs_sum = abs_base + {8'h00, (item.mode == MODE_ABSY) ? item.index_y : item.index_x};
	end

	// Direct modes; loads and implied or unused codes give all zeros.
	always_comb begin
		dir_ea    = '0;
		dir_extra = 1'b0;
		dir_acc   = 1'b0;
		if (is_resolve) begin
			unique case (item.mode)
				MODE_IMM:  dir_ea = item.pc + 16'd1;
				MODE_ZP:   dir_ea = {8'h00, item.operand_low};
				MODE_ZPX:  dir_ea = {8'h00, zp_x};
				MODE_ZPY:  dir_ea = {8'h00, 8'(item.operand_low + item.index_y)};
				MODE_ABS:  dir_ea = abs_base;
				MODE_ABSX, MODE_ABSY: begin
					dir_ea    = abs_sum;
					dir_extra = (abs_sum[15:8] != item.operand_high);
				end
				MODE_REL:  dir_ea = item.pc + 16'd2 + {{8{item.operand_low[7]}}, item.operand_low};
				MODE_ACC:  dir_acc = 1'b1;
				default: begin
				end
			endcase
		end
	end

	// Pointer locations; only the JMP indirect pointer leaves page zero, and
	// its high byte comes from the same page (the page-wrap quirk).
	always_comb begin
		unique case (item.mode)
			MODE_INDX: begin
				ptr_lo_addr = {8'h00, zp_x};
				ptr_hi_addr = {8'h00, 8'(zp_x + 8'd1)};
			end
			MODE_INDY: begin
				ptr_lo_addr = {8'h00, item.operand_low};
				ptr_hi_addr = {8'h00, 8'(item.operand_low + 8'd1)};
			end
			default: begin
				ptr_lo_addr = abs_base;
				ptr_hi_addr = {item.operand_high, 8'(item.operand_low + 8'd1)};
			end
		endcase
	end

	// Store port: loads write and indirect transactions read the low pointer
	// byte in the accept cycle, the high pointer byte in the next cycle.
	always_comb begin
		sreq.en    = 1'b0;
		sreq.we    = 1'b0;
		sreq.addr  = ptr_hi_addr_q;
		sreq.wdata = item.store_data;
		if (state_q == S_RD_HI) begin
			sreq.en = 1'b1;
		end else if (accept && !is_resolve) begin
			sreq.en   = 1'b1;
			sreq.we   = 1'b1;
			sreq.addr = item.store_address;
		end else if (accept && is_indirect) begin
			sreq.en   = 1'b1;
			sreq.addr = ptr_lo_addr;
		end
	end

	oau_store #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.req  (sreq),
		.rdata(srdata)
	);

	assign ptr       = {srdata, ptr_lo_q};
	assign ind_sum   = ptr + {8'h00, y_q};
	assign ind_ea    = (mode_q == MODE_INDY) ? ind_sum : ptr;
	assign ind_extra = (mode_q == MODE_INDY) && (ind_sum[15:8] != ptr[15:8]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			m_tvalid_q    <= 1'b0;
			ea_q          <= '0;
			extra_q       <= 1'b0;
			acc_q         <= 1'b0;
			mode_q        <= '0;
			y_q           <= '0;
			ptr_hi_addr_q <= '0;
			ptr_lo_q      <= '0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_indirect) begin
							state_q       <= S_RD_HI;
							mode_q        <= item.mode;
							y_q           <= item.index_y;
							ptr_hi_addr_q <= ptr_hi_addr;
						end else begin
							ea_q       <= dir_ea;
							extra_q    <= dir_extra;
							acc_q      <= dir_acc;
						end
					end
				end
				S_RD_HI: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					// Output register was emptied when this transaction was taken.
					state_q    <= S_IDLE;
					ea_q       <= ind_ea;
					extra_q    <= ind_extra;
					acc_q      <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (state_q == S_RD_HI) begin
				ptr_lo_q <= srdata;
			end
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = {7'b0, extra_q, ea_q};
	assign m_tuser[0] = acc_q;

	// An indirect result always finds the output register free.
	`OAU_ASSERT_IMPLY(a_done_out_free, clk, arst_n, (state_q == S_DONE), (!m_tvalid_q))
	// An accepted indirect resolve starts the two-read sequence.
	`OAU_ASSERT_NEXT(a_ind_start, clk, arst_n, (accept && is_indirect), (state_q == S_RD_HI))
	// The high pointer read is always followed by the result cycle.
	`OAU_ASSERT_NEXT(a_rd_hi_done, clk, arst_n, (state_q == S_RD_HI), (state_q == S_DONE))
	// A direct transaction delivers its result at the next edge.
	`OAU_ASSERT_NEXT(a_direct_result, clk, arst_n, (accept && !is_indirect), (m_tvalid_q))
	// The store is never written while a pointer read is in flight.
	`OAU_ASSERT_IMPLY(a_no_write_busy, clk, arst_n, (state_q != S_IDLE), (!sreq.we))

endmodule

/* rtl/oau_store.sv */
// Single-port synchronous byte store for the operand address unit.
// Depends on oau_pkg; the address is reduced modulo STORE_DEPTH.
module oau_store #(
	parameter int STORE_DEPTH = oau_pkg::STORE_DEPTH_DEF
) (
	input  logic                             clk,
	input  oau_pkg::store_req_t              req,
	output logic [oau_pkg::DATA_W-1:0]       rdata
);
	import oau_pkg::*;

	// STORE_DEPTH is a power of two, so the modulo is a plain bit select.
	localparam int AW = $clog2(STORE_DEPTH);

	logic [DATA_W-1:0] mem [STORE_DEPTH];
	logic [AW-1:0]     idx;
	logic [DATA_W-1:0] rdata_q;

	assign idx   = req.addr[AW-1:0];
	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[idx] <= req.wdata;
			end else begin
				rdata_q <= mem[idx];
			end
		end
	end

endmodule
